/* design/sacl_pkg.sv */
// shared constants and types for the set-associative lru tag store
`timescale 1ns / 1ps
`default_nettype none

package sacl_pkg;

   // default geometry
   localparam int DEF_WAYS = 4;
   localparam int DEF_SETS = 1024;

   // field widths
   localparam int ADDR_W       = 31;
   localparam int SUM_W        = 32;
   localparam int BLOCK_BITS_W = 5;
   localparam int OFFSET_W     = 10;
   localparam int COUNT_W      = 32;
   localparam int WAY_OUT_W    = 2;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 10;

   // register reset values and limits
   localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RESET = 5'd12;
   localparam logic [OFFSET_W-1:0]     OFFSET_RESET     = '0;
   localparam logic [COUNT_W-1:0]      COUNT_MAX        = '1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_BITS  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ADDR_OFFSET = 1'b1;

   // control states
   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } state_type;

endpackage

`default_nettype wire

/* design/sacl_req_if.sv */
// request channel carrying one byte address
`timescale 1ns / 1ps
`default_nettype none

interface sacl_req_if
   import sacl_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] address;

   modport source (output valid, output address, input ready);
   modport sink   (input valid, input address, output ready);
endinterface

`default_nettype wire

/* design/sacl_rsp_if.sv */
// response channel carrying lookup outcome and running counts
`timescale 1ns / 1ps
`default_nettype none

interface sacl_rsp_if
   import sacl_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic                 hit;
   logic [WAY_OUT_W-1:0] way_used;
   logic [COUNT_W-1:0]   hit_count;
   logic [COUNT_W-1:0]   miss_count;

   modport source (output valid, output hit, output way_used, output hit_count,
                   output miss_count, input ready);
   modport sink   (input valid, input hit, input way_used, input hit_count,
                   input miss_count, output ready);
endinterface

`default_nettype wire

/* design/sacl_csr_if.sv */
// configuration write channel
`timescale 1ns / 1ps
`default_nettype none

interface sacl_csr_if
   import sacl_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* design/set_assoc_lru_cache_tags_core.sv */
// Set-associative lru tag store. Accepting a request reads the set memory and loads the
// lookup stage; compare, write back and response register follow as that stage advances,
// which response back-pressure can stall. Throughput: one request per cycle while responses
// are taken; a request to the set written in the same cycle takes the written row from a
// forwarding register instead of the set memory. Reset: a clearing pass sweeps the set
// memory one set per cycle, holding off requests; configuration writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_lru_cache_tags_core
   import sacl_pkg::*;
#(
   parameter int WAYS = DEF_WAYS,
   parameter int SETS = DEF_SETS
) (
   input wire logic   clock,
   input wire logic   reset,
   sacl_req_if.sink   req_bus,
   sacl_rsp_if.source rsp_bus,
   sacl_csr_if.sink   csr_bus
);

   localparam int SET_BITS = $clog2(SETS);
   localparam int IDX_W    = (SET_BITS > 0) ? SET_BITS : 1;
   localparam int TAG_W    = SUM_W - SET_BITS;
   localparam int RANK_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int WAY_W    = RANK_W;
   localparam int ENT_W    = 1 + RANK_W + TAG_W;
   localparam int ROW_W    = WAYS * ENT_W;

   // configuration registers
   logic [BLOCK_BITS_W-1:0] block_bits_ff, block_bits_in;
   logic [OFFSET_W-1:0]     offset_ff, offset_in;

   // control
   state_type               state_ff, state_in;
   logic [IDX_W-1:0]        clr_idx_ff, clr_idx_in;
   logic                    clearing;
   logic                    clr_last;

   // request decode
   logic                    accept;
   logic [SUM_W-1:0]        sum;
   logic [SUM_W-1:0]        block;
   logic [IDX_W-1:0]        req_set;
   logic [TAG_W-1:0]        req_tag;

   // lookup stage
   logic                    s1_valid_ff, s1_valid_in;
   logic [IDX_W-1:0]        s1_set_ff, s1_set_in;
   logic [TAG_W-1:0]        s1_tag_ff, s1_tag_in;
   logic                    fwd_sel_ff, fwd_sel_in;
   logic [ROW_W-1:0]        fwd_row_ff, fwd_row_in;
   logic                    s1_go;

   // set memory
   logic [ROW_W-1:0]        rd_row;
   logic [ROW_W-1:0]        cur_row;
   logic [ROW_W-1:0]        new_row;
   logic [ROW_W-1:0]        clr_row;
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   logic [ROW_W-1:0]        wr_row;

   // row fields
   logic [WAYS-1:0]             cur_valid, nxt_valid;
   logic [WAYS-1:0][RANK_W-1:0] cur_rank, nxt_rank;
   logic [WAYS-1:0][TAG_W-1:0]  cur_tag, nxt_tag;
   logic                        lk_hit;
   logic [WAY_W-1:0]            lk_way;
   logic [WAYS-1:0]             mru_vec;

   // response registers, counts double as running totals
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_hit_ff, rsp_hit_in;
   logic [WAY_OUT_W-1:0]    rsp_way_ff, rsp_way_in;
   logic [COUNT_W-1:0]      hit_count_ff, hit_count_in;
   logic [COUNT_W-1:0]      miss_count_ff, miss_count_in;

   // configuration writes
   assign csr_bus.ready = 1'b1;

   always_comb begin
      block_bits_in = block_bits_ff;
      offset_in     = offset_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_BLOCK_BITS:  block_bits_in = csr_bus.data[BLOCK_BITS_W-1:0];
            CSR_ADDR_OFFSET: offset_in     = csr_bus.data[OFFSET_W-1:0];
            default:         ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_bits_ff <= BLOCK_BITS_RESET;
         offset_ff     <= OFFSET_RESET;
      end else begin
         block_bits_ff <= block_bits_in;
         offset_ff     <= offset_in;
      end
   end

   // clearing sweep state machine: next state
   assign clr_last = (clr_idx_ff == IDX_W'(SETS - 1));

   always_comb begin
      case (state_ff)
         ST_CLEAR: state_in = clr_last ? ST_RUN : ST_CLEAR;
         ST_RUN:   state_in = ST_RUN;
         default:  state_in = ST_CLEAR;
      endcase
   end

   // clearing sweep state machine: outputs
   always_comb begin
      case (state_ff)
         ST_CLEAR: clearing = 1'b1;
         ST_RUN:   clearing = 1'b0;
         default:  clearing = 1'b0;
      endcase
   end

   assign clr_idx_in = clearing ? (clr_idx_ff + IDX_W'(1)) : clr_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_idx_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_idx_ff <= clr_idx_in;
      end
   end

   // request handshake and address split
   assign s1_go         = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !clearing && (!s1_valid_ff || s1_go);
   assign accept        = req_bus.valid && req_bus.ready;

   assign sum     = SUM_W'(req_bus.address) + SUM_W'(offset_ff);
   assign block   = sum >> block_bits_ff;
   assign req_set = IDX_W'(block & SUM_W'(SETS - 1));
   assign req_tag = TAG_W'(block >> SET_BITS);

   // lookup stage registers and same-set forwarding
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_set_in   = s1_set_ff;
      s1_tag_in   = s1_tag_ff;
      fwd_sel_in  = fwd_sel_ff;
      fwd_row_in  = fwd_row_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_set_in   = req_set;
         s1_tag_in   = req_tag;
         fwd_sel_in  = s1_go && (s1_set_ff == req_set);
         fwd_row_in  = new_row;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
         fwd_sel_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_sel_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         fwd_sel_ff  <= fwd_sel_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_set_ff  <= s1_set_in;
      s1_tag_ff  <= s1_tag_in;
      fwd_row_ff <= fwd_row_in;
   end

   // set memory
   assign wr_en   = clearing || s1_go;
   assign wr_addr = clearing ? clr_idx_ff : s1_set_ff;
   assign wr_row  = clearing ? clr_row : new_row;

   sacl_tag_ram #(
      .DEPTH  (SETS),
      .IDX_W  (IDX_W),
      .DATA_W (ROW_W)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_row),
      .rd_en   (accept),
      .rd_addr (req_set),
      .rd_data (rd_row)
   );

   // row pack and unpack
   assign cur_row = fwd_sel_ff ? fwd_row_ff : rd_row;

   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         cur_valid[w] = cur_row[w*ENT_W + ENT_W - 1];
         cur_rank[w]  = cur_row[w*ENT_W + TAG_W +: RANK_W];
         cur_tag[w]   = cur_row[w*ENT_W +: TAG_W];
         new_row[w*ENT_W +: ENT_W] = {nxt_valid[w], nxt_rank[w], nxt_tag[w]};
         clr_row[w*ENT_W +: ENT_W] = {1'b0, RANK_W'(w), {TAG_W{1'b0}}};
         mru_vec[w]   = (nxt_rank[w] == RANK_W'(WAYS - 1));
      end
   end

   sacl_lookup #(
      .WAYS   (WAYS),
      .TAG_W  (TAG_W),
      .RANK_W (RANK_W),
      .WAY_W  (WAY_W)
   ) u_lookup (
      .rd_valid (cur_valid),
      .rd_rank  (cur_rank),
      .rd_tag   (cur_tag),
      .tag      (s1_tag_ff),
      .hit      (lk_hit),
      .way      (lk_way),
      .wr_valid (nxt_valid),
      .wr_rank  (nxt_rank),
      .wr_tag   (nxt_tag)
   );

   // response register and saturating counts
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_way_in    = rsp_way_ff;
      hit_count_in  = hit_count_ff;
      miss_count_in = miss_count_ff;
      if (s1_go) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = lk_hit;
         rsp_way_in   = WAY_OUT_W'(lk_way);
         if (lk_hit && (hit_count_ff != COUNT_MAX)) begin
            hit_count_in = hit_count_ff + COUNT_W'(1);
         end
         if (!lk_hit && (miss_count_ff != COUNT_MAX)) begin
            miss_count_in = miss_count_ff + COUNT_W'(1);
         end
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         hit_count_ff  <= '0;
         miss_count_ff <= '0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         hit_count_ff  <= hit_count_in;
         miss_count_ff <= miss_count_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff <= rsp_hit_in;
      rsp_way_ff <= rsp_way_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.hit        = rsp_hit_ff;
   assign rsp_bus.way_used   = rsp_way_ff;
   assign rsp_bus.hit_count  = hit_count_ff;
   assign rsp_bus.miss_count = miss_count_ff;

   // checks
   a_no_req_while_clearing : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_bus.ready)
      else $error("request accepted during clearing sweep");

   a_fwd_needs_item : assert property (@(posedge clock) disable iff (reset)
      fwd_sel_ff |-> s1_valid_ff)
      else $error("forwarded row selected with no request in lookup");

   a_single_mru : assert property (@(posedge clock) disable iff (reset)
      s1_go |-> $onehot(mru_vec))
      else $error("written set does not hold exactly one most recent way");

   a_hit_count_step : assert property (@(posedge clock) disable iff (reset)
      (s1_go && lk_hit && (hit_count_ff != COUNT_MAX))
         |=> (hit_count_ff == ($past(hit_count_ff) + COUNT_W'(1))))
      else $error("hit count did not advance on a hit");

endmodule

`default_nettype wire

/* design/sacl_tag_ram.sv */
// one-write one-read set memory with registered read data
`timescale 1ns / 1ps
`default_nettype none

module sacl_tag_ram
   import sacl_pkg::*;
#(
   parameter int DEPTH  = DEF_SETS,
   parameter int IDX_W  = 10,
   parameter int DATA_W = 100
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [IDX_W-1:0]  wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [IDX_W-1:0]  rd_addr,
   output      logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* design/sacl_lookup.sv */
// tag compare, victim choice and lru rank update for one set
`timescale 1ns / 1ps
`default_nettype none

module sacl_lookup
   import sacl_pkg::*;
#(
   parameter int WAYS   = DEF_WAYS,
   parameter int TAG_W  = 22,
   parameter int RANK_W = 2,
   parameter int WAY_W  = 2
) (
   input  wire logic [WAYS-1:0]             rd_valid,
   input  wire logic [WAYS-1:0][RANK_W-1:0] rd_rank,
   input  wire logic [WAYS-1:0][TAG_W-1:0]  rd_tag,
   input  wire logic [TAG_W-1:0]            tag,
   output      logic                        hit,
   output      logic [WAY_W-1:0]            way,
   output      logic [WAYS-1:0]             wr_valid,
   output      logic [WAYS-1:0][RANK_W-1:0] wr_rank,
   output      logic [WAYS-1:0][TAG_W-1:0]  wr_tag
);

   logic [WAY_W-1:0]  hit_way;
   logic [WAY_W-1:0]  inv_way;
   logic [WAY_W-1:0]  lru_way;
   logic              any_inv;
   logic [RANK_W-1:0] old_rank;

   // priority searches, lowest way wins
   always_comb begin
      hit     = 1'b0;
      any_inv = 1'b0;
      hit_way = '0;
      inv_way = '0;
      lru_way = '0;
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (rd_valid[i] && (rd_tag[i] == tag)) begin
            hit     = 1'b1;
            hit_way = WAY_W'(i);
         end
         if (!rd_valid[i]) begin
            any_inv = 1'b1;
            inv_way = WAY_W'(i);
         end
         if (rd_rank[i] == '0) begin
            lru_way = WAY_W'(i);
         end
      end
   end

   // way used: hit way, else first free way, else least recent
   always_comb begin
      if (hit) begin
         way = hit_way;
      end else if (any_inv) begin
         way = inv_way;
      end else begin
         way = lru_way;
      end
   end

   // promote chosen way to most recent, fill on miss
   always_comb begin
      old_rank = rd_rank[way];
      wr_valid = rd_valid;
      wr_tag   = rd_tag;
      for (int i = 0; i < WAYS; i++) begin
         if (rd_rank[i] > old_rank) begin
            wr_rank[i] = rd_rank[i] - RANK_W'(1);
         end else begin
            wr_rank[i] = rd_rank[i];
         end
      end
      wr_rank[way] = RANK_W'(WAYS - 1);
      if (!hit) begin
         wr_tag[way]   = tag;
         wr_valid[way] = 1'b1;
      end
   end

endmodule

`default_nettype wire
